/* hdl/vertex_transform_perspective_divide_top_macros.svh */
// Assertion macros shared by the checker of the vertex transform block.
// Depends on nothing; included by files that carry assertions.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_TOP_MACROS_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VTPD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define VTPD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// A check that also runs while reset is asserted.
`define VTPD_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset check failed");

`endif

/* hdl/vtpd_pkg.sv */
// Types and constants of the vertex transform block.
// Depends on nothing; used by vtpd_dot, the top level and the checker.
package vtpd_pkg;

    localparam int CW = 32;
    localparam int EW = 32;
    localparam int PW = CW + EW;
    localparam int DW = PW + 2;
    localparam int MAT_REGS = 8;
    localparam int REG_W = 64;
    localparam int IDX_W = 4;

    localparam logic CMD_DIRECTION = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    localparam logic [REG_W-1:0] MAT_RESET [0:MAT_REGS-1] = '{
        64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
        64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
    };

    typedef struct packed {
        logic cmd;
        logic signed [CW-1:0] in_x;
        logic signed [CW-1:0] in_y;
        logic signed [CW-1:0] in_z;
        logic signed [CW-1:0] in_w;
    } in_t;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
        logic w_zero;
        logic overflow;
    } out_t;

    typedef logic [MAT_REGS-1:0][REG_W-1:0] mat_t;

endpackage

/* hdl/vtpd_dot.sv */
// Two pipeline stages: sixteen matrix-by-component products, then four row sums.
// Depends on vtpd_pkg.
module vtpd_dot (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic                                 in_cmd,
    input  logic [3:0][vtpd_pkg::CW-1:0]         in_vec,
    input  vtpd_pkg::mat_t                       mat,
    output logic                                 out_valid,
    output logic                                 out_cmd,
    output logic [3:0][vtpd_pkg::DW-1:0]         out_dot
);

    logic [3:0][3:0][vtpd_pkg::PW-1:0] prod_reg, prod_next;
    logic [3:0][vtpd_pkg::DW-1:0]      dot_reg, dot_next;
    logic prod_valid_reg, prod_cmd_reg, dot_valid_reg, dot_cmd_reg;

    always_comb begin
        logic [vtpd_pkg::EW-1:0] e;
        logic [vtpd_pkg::CW-1:0] v;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                e = mat[r * 2 + c / 2][(c % 2) * 32 +: 32];
                v = (c == 3 && r < 3 && in_cmd == vtpd_pkg::CMD_DIRECTION) ? '0 : in_vec[c];
                prod_next[r][c] = $signed({{vtpd_pkg::CW{e[vtpd_pkg::EW-1]}}, e})
                                * $signed({{vtpd_pkg::EW{v[vtpd_pkg::CW-1]}}, v});
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            dot_next[r] = '0;
            for (int c = 0; c < 4; c++) begin
                dot_next[r] = dot_next[r]
                    + {{2{prod_reg[r][c][vtpd_pkg::PW-1]}}, prod_reg[r][c]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            dot_valid_reg  <= 1'b0;
        end else if (en) begin
            prod_valid_reg <= in_valid;
            dot_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg     <= prod_next;
            prod_cmd_reg <= in_cmd;
            dot_reg      <= dot_next;
            dot_cmd_reg  <= prod_cmd_reg;
        end
    end

    assign out_valid = dot_valid_reg;
    assign out_cmd   = dot_cmd_reg;
    assign out_dot   = dot_reg;

endmodule

/* hdl/vtpd_div.sv */
// Pipelined restoring divider, one quotient bit per stage, lanes sharing one divisor.
// Depends on nothing; instantiated by the top level.
module vtpd_div #(
    parameter int NUM_W  = 84,
    parameter int DEN_W  = 67,
    parameter int LANES  = 3,
    parameter int META_W = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]     in_num,
    input  logic [DEN_W-1:0]                in_den,
    input  logic [META_W-1:0]               in_meta,
    output logic                            out_valid,
    output logic [LANES-1:0][NUM_W-1:0]     out_quo,
    output logic [META_W-1:0]               out_meta
);

    logic                            valid_reg [0:NUM_W-1];
    logic [LANES-1:0][NUM_W-1:0]     num_reg   [0:NUM_W-1];
    logic [LANES-1:0][NUM_W-1:0]     quo_reg   [0:NUM_W-1];
    logic [LANES-1:0][DEN_W-1:0]     rem_reg   [0:NUM_W-1];
    logic [DEN_W-1:0]                den_reg   [0:NUM_W-1];
    logic [META_W-1:0]               meta_reg  [0:NUM_W-1];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic                        src_valid;
        logic [LANES-1:0][NUM_W-1:0] src_num, src_quo, num_next, quo_next;
        logic [LANES-1:0][DEN_W-1:0] src_rem, rem_next;
        logic [DEN_W-1:0]            src_den;
        logic [META_W-1:0]           src_meta;

        if (k == 0) begin : g_first
            assign src_valid = in_valid;
            assign src_num   = in_num;
            assign src_quo   = '0;
            assign src_rem   = '0;
            assign src_den   = in_den;
            assign src_meta  = in_meta;
        end else begin : g_next
            assign src_valid = valid_reg[k-1];
            assign src_num   = num_reg[k-1];
            assign src_quo   = quo_reg[k-1];
            assign src_rem   = rem_reg[k-1];
            assign src_den   = den_reg[k-1];
            assign src_meta  = meta_reg[k-1];
        end

        always_comb begin
            logic [DEN_W:0] trial;
            logic [DEN_W:0] diff;
            logic           ge;
            for (int l = 0; l < LANES; l++) begin
                trial       = {src_rem[l], src_num[l][NUM_W-1]};
                diff        = trial - {1'b0, src_den};
                ge          = trial >= {1'b0, src_den};
                rem_next[l] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                num_next[l] = {src_num[l][NUM_W-2:0], 1'b0};
                quo_next[l] = {src_quo[l][NUM_W-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k]  <= num_next;
                quo_reg[k]  <= quo_next;
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= src_den;
                meta_reg[k] <= src_meta;
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_quo   = quo_reg[NUM_W-1];
    assign out_meta  = meta_reg[NUM_W-1];

endmodule

/* hdl/vertex_transform_perspective_divide_top.sv */
// Top level of the 4x4 vertex transform with perspective divide.
// Depends on vtpd_pkg, vtpd_dot and vtpd_div.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_data (vtpd_pkg::in_t)
//  m_        out        m_valid/m_ready    m_data (vtpd_pkg::out_t)
//  cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// One item per cycle while no stall on m_ready holds the pipeline; the divider
// spends one stage on each of its FRAC_BITS + 68 quotient bits.
// Reset restores the identity matrix and empties the pipeline.
// A stall on m_ready freezes every stage, and s_ready follows it.
module vertex_transform_perspective_divide_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  vtpd_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output vtpd_pkg::out_t                m_data,
    input  logic                          cfg_we,
    input  logic [vtpd_pkg::IDX_W-1:0]    cfg_index,
    input  logic [vtpd_pkg::REG_W-1:0]    cfg_wdata
);

    localparam int CW   = vtpd_pkg::CW;
    localparam int DW   = vtpd_pkg::DW;
    localparam int NW   = DW + FRAC_BITS + 2;
    localparam int DENW = DW + 1;
    localparam int MW   = 3 + 3 * CW + 3;

    localparam logic [DW-1:0] D_MAX = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic [DW-1:0] D_MIN = {{(DW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic [DW-1:0] D_HALF = DW'(1) << (FRAC_BITS - 1);
    localparam logic [NW-1:0] Q_MAX = {{(NW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic [NW-1:0] Q_MIN_MAG = NW'(1) << (CW - 1);
    localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    logic [vtpd_pkg::REG_W-1:0] mat_reg [0:vtpd_pkg::MAT_REGS-1];
    vtpd_pkg::mat_t mat;

    logic en;
    logic a_valid_reg;
    vtpd_pkg::in_t a_data_reg;

    logic dot_valid, dot_cmd;
    logic [3:0][DW-1:0] dot;

    logic p_valid_reg;
    logic [2:0][NW-1:0] p_num_reg, p_num_next;
    logic [DENW-1:0] p_den_reg, p_den_next;
    logic [MW-1:0] p_meta_reg, p_meta_next;

    logic div_valid;
    logic [2:0][NW-1:0] div_quo;
    logic [MW-1:0] div_meta;

    logic m_valid_reg;
    vtpd_pkg::out_t m_data_reg, m_data_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < vtpd_pkg::MAT_REGS; i++) begin
                mat_reg[i] <= vtpd_pkg::MAT_RESET[i];
            end
        end else if (cfg_we && cfg_index < vtpd_pkg::IDX_W'(vtpd_pkg::MAT_REGS)) begin
            mat_reg[cfg_index[2:0]] <= cfg_wdata;
        end
    end

    always_comb begin
        for (int i = 0; i < vtpd_pkg::MAT_REGS; i++) begin
            mat[i] = mat_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
            p_valid_reg <= dot_valid;
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_data_reg <= s_data;
            p_num_reg  <= p_num_next;
            p_den_reg  <= p_den_next;
            p_meta_reg <= p_meta_next;
            m_data_reg <= m_data_next;
        end
    end

    vtpd_dot u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a_valid_reg),
        .in_cmd    (a_data_reg.cmd),
        .in_vec    ({a_data_reg.in_w, a_data_reg.in_z, a_data_reg.in_y, a_data_reg.in_x}),
        .mat       (mat),
        .out_valid (dot_valid),
        .out_cmd   (dot_cmd),
        .out_dot   (dot)
    );

    // Operand preparation: signs, magnitudes, rounding offsets and the direction result.
    always_comb begin
        logic          dneg, nneg, wz, dir_ov;
        logic [DW-1:0] dmag, nmag, acc, sh;
        logic [2:0]    qneg;
        logic [2:0][CW-1:0] dir;
        dneg   = dot[3][DW-1];
        dmag   = dneg ? -dot[3] : dot[3];
        wz     = (dot_cmd == vtpd_pkg::CMD_POINT) && (dot[3] == '0);
        dir_ov = 1'b0;
        for (int r = 0; r < 3; r++) begin
            nneg          = dot[r][DW-1];
            nmag          = nneg ? -dot[r] : dot[r];
            qneg[r]       = nneg ^ dneg;
            p_num_next[r] = NW'({nmag, {(FRAC_BITS+1){1'b0}}}) + NW'(dmag);
            acc           = dot[r] + D_HALF;
            sh            = $signed(acc) >>> FRAC_BITS;
            if ($signed(sh) > $signed(D_MAX)) begin
                dir[r] = C_MAX;
                dir_ov = 1'b1;
            end else if ($signed(sh) < $signed(D_MIN)) begin
                dir[r] = C_MIN;
                dir_ov = 1'b1;
            end else begin
                dir[r] = sh[CW-1:0];
            end
        end
        p_den_next  = {dmag, 1'b0};
        p_meta_next = {dot_cmd, wz, dir_ov, dir[0], dir[1], dir[2], qneg};
    end

    vtpd_div #(
        .NUM_W  (NW),
        .DEN_W  (DENW),
        .LANES  (3),
        .META_W (MW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p_valid_reg),
        .in_num    (p_num_reg),
        .in_den    (p_den_reg),
        .in_meta   (p_meta_reg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_meta  (div_meta)
    );

    // Result selection and saturation of the quotients.
    always_comb begin
        logic          cmd, wz, dir_ov, ov;
        logic [2:0]    qneg;
        logic [2:0][CW-1:0] dir, res;
        logic [CW-1:0] qlow;
        {cmd, wz, dir_ov, dir[0], dir[1], dir[2], qneg} = div_meta;
        ov = 1'b0;
        for (int r = 0; r < 3; r++) begin
            qlow = div_quo[r][CW-1:0];
            if (qneg[r]) begin
                if (div_quo[r] > Q_MIN_MAG) begin
                    res[r] = C_MIN;
                    ov     = 1'b1;
                end else begin
                    res[r] = -qlow;
                end
            end else if (div_quo[r] > Q_MAX) begin
                res[r] = C_MAX;
                ov     = 1'b1;
            end else begin
                res[r] = qlow;
            end
        end
        if (cmd == vtpd_pkg::CMD_DIRECTION) begin
            m_data_next.out_x    = dir[0];
            m_data_next.out_y    = dir[1];
            m_data_next.out_z    = dir[2];
            m_data_next.w_zero   = 1'b0;
            m_data_next.overflow = dir_ov;
        end else if (wz) begin
            m_data_next.out_x    = '0;
            m_data_next.out_y    = '0;
            m_data_next.out_z    = '0;
            m_data_next.w_zero   = 1'b1;
            m_data_next.overflow = 1'b0;
        end else begin
            m_data_next.out_x    = res[0];
            m_data_next.out_y    = res[1];
            m_data_next.out_z    = res[2];
            m_data_next.w_zero   = 1'b0;
            m_data_next.overflow = ov;
        end
    end

endmodule

/* hdl/vtpd_checker.sv */
// Port-level checker for the vertex transform block, bound to the top level.
// Depends on vtpd_pkg and vertex_transform_perspective_divide_top_macros.svh.
`include "vertex_transform_perspective_divide_top_macros.svh"

module vtpd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input vtpd_pkg::out_t                m_data
);

    `VTPD_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data))
    `VTPD_ASSERT_SAME(a_wzero_no_ovf, aclk, aresetn, m_valid && m_data.w_zero,
        !m_data.overflow)
    `VTPD_ASSERT_SAME(a_wzero_zero_out, aclk, aresetn, m_valid && m_data.w_zero,
        m_data.out_x == 0 && m_data.out_y == 0 && m_data.out_z == 0)
    `VTPD_ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind vertex_transform_perspective_divide_top vtpd_checker u_vtpd_checker (.*);
